### rtl/b64d_pkg.sv
package b64d_pkg;

    localparam logic [7:0] CHAR_PAD  = 8'h3D;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] ASCII_MAX = 8'd127;
    localparam logic [6:0] PAD_VALUE = 7'd64;
    localparam logic [5:0] SYM_MASK  = 6'h3F;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        logic       ok;
        logic       pad;
        logic [5:0] val;
    } sym_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
    } result_t;

    typedef struct packed {
        logic [2:0]    count;
        result_t [3:0] res;
    } group_t;

    function automatic sym_t symbol_map(input logic [7:0] c);
        sym_t s;
        s.ok  = 1'b1;
        s.pad = 1'b0;
        s.val = '0;
        if (c > ASCII_MAX) begin
            s.ok = 1'b0;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            s.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.val = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.val = 6'd62;
        end else if (c == 8'h2F) begin
            s.val = 6'd63;
        end else if (c == CHAR_PAD) begin
            s.pad = 1'b1;
            s.val = 6'(PAD_VALUE) & SYM_MASK;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

### rtl/b64d_decode.sv
module b64d_decode (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_in_char,
    input  logic            s_in_last,
    output logic            grp_valid,
    input  logic            grp_ready,
    output b64d_pkg::group_t grp
);
    import b64d_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    logic        pop;

    logic [23:0] acc_reg, acc_next;
    logic [1:0]  sym_cnt_reg, sym_cnt_next;
    logic [1:0]  pad_cnt_reg, pad_cnt_next;
    logic        pend_reg, pend_next;
    logic        err_reg, err_next;

    assign pop       = in_valid_reg && grp_ready;
    assign s_ready   = !in_valid_reg || pop;
    assign grp_valid = in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_char_reg <= s_in_char;
            in_last_reg <= s_in_last;
        end
    end

    always_comb begin
        sym_t       s;
        logic       bad;
        logic       emit;
        logic [1:0] k;
        logic [1:0] ndata;
        logic [7:0] b [3];
        s            = symbol_map(in_char_reg);
        bad          = 1'b0;
        emit         = 1'b0;
        k            = '0;
        ndata        = '0;
        b            = '{default: '0};
        acc_next     = acc_reg;
        sym_cnt_next = sym_cnt_reg;
        pad_cnt_next = pad_cnt_reg;
        pend_next    = pend_reg;
        err_next     = err_reg;
        grp          = '0;

        if (err_reg) begin
            if (in_last_reg) begin
                err_next = 1'b0;
                acc_next = '0;
                sym_cnt_next = '0;
                pad_cnt_next = '0;
                pend_next = 1'b0;
            end
        end else begin
            if (pend_reg) begin
                pend_next = 1'b0;
                bad = (in_char_reg != CHAR_LF);
            end else if (in_char_reg == CHAR_CR) begin
                if (in_last_reg) bad = 1'b1;
                else pend_next = 1'b1;
            end else if (in_char_reg != CHAR_LF) begin
                if (!s.ok) begin
                    bad = 1'b1;
                end else if (s.pad) begin
                    if (pad_cnt_reg >= 2'd2) bad = 1'b1;
                    else pad_cnt_next = pad_cnt_reg + 2'd1;
                end else if (pad_cnt_reg != 2'd0) begin
                    bad = 1'b1;
                end
                if (!bad) begin
                    acc_next = {acc_reg[17:0], s.val & SYM_MASK};
                    if (sym_cnt_reg == 2'd3) begin
                        sym_cnt_next = '0;
                        emit = 1'b1;
                    end else begin
                        sym_cnt_next = sym_cnt_reg + 2'd1;
                    end
                end
            end

            k     = 2'd3 - pad_cnt_next;
            ndata = emit ? k : 2'd0;
            b[0]  = acc_next[23:16];
            b[1]  = acc_next[15:8];
            b[2]  = acc_next[7:0];
            for (int i = 0; i < 3; i++) begin
                grp.res[i].data = b[i];
                grp.res[i].kind = KIND_DATA;
            end

            if (bad) begin
                grp.res[0].data = '0;
                grp.res[0].kind = KIND_ERROR;
                grp.count = 3'd1;
                err_next = 1'b1;
            end else if (in_last_reg) begin
                grp.res[ndata].data = '0;
                grp.res[ndata].kind = KIND_END;
                grp.count = {1'b0, ndata} + 3'd1;
            end else begin
                grp.count = {1'b0, ndata};
            end

            if (in_last_reg) begin
                err_next = 1'b0;
                acc_next = '0;
                sym_cnt_next = '0;
                pad_cnt_next = '0;
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            sym_cnt_reg <= '0;
            pad_cnt_reg <= '0;
            pend_reg    <= 1'b0;
            err_reg     <= 1'b0;
        end else if (pop) begin
            acc_reg     <= acc_next;
            sym_cnt_reg <= sym_cnt_next;
            pad_cnt_reg <= pad_cnt_next;
            pend_reg    <= pend_next;
            err_reg     <= err_next;
        end
    end

endmodule

### rtl/b64d_serializer.sv
module b64d_serializer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             grp_valid,
    output logic             grp_ready,
    input  b64d_pkg::group_t grp,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic [1:0]       m_out_kind,
    output logic             m_out_last
);
    import b64d_pkg::*;

    group_t     grp_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       at_end;
    logic       load;

    assign at_end    = ({1'b0, idx_reg} == grp_reg.count - 3'd1);
    assign grp_ready = !valid_reg || (m_ready && at_end);
    assign load      = grp_valid && grp_ready;

    assign m_valid    = valid_reg;
    assign m_out_byte = grp_reg.res[idx_reg].data;
    assign m_out_kind = grp_reg.res[idx_reg].kind;
    assign m_out_last = at_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= (grp.count != 3'd0);
            idx_reg   <= '0;
        end else if (valid_reg && m_ready) begin
            if (at_end) begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
        if (load) begin
            grp_reg <= grp;
        end
    end

endmodule

### rtl/base64_stream_decoder_core.sv
// A character is held in the input stage, its results in the result register.
// Throughput: one character per cycle while each yields at most one result
// and m_ready is high; extra results hold the result register until taken.
// Reset: aresetn is synchronous, active low; it clears the decoder state,
// the input stage and the result register.
module base64_stream_decoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_out_kind,
    output logic       m_out_last
);
    import b64d_pkg::*;

    logic   grp_valid;
    logic   grp_ready;
    group_t grp;

    b64d_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_char (s_in_char),
        .s_in_last (s_in_last),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp)
    );

    b64d_serializer u_serializer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .grp_valid  (grp_valid),
        .grp_ready  (grp_ready),
        .grp        (grp),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_kind (m_out_kind),
        .m_out_last (m_out_last)
    );

endmodule
